### sv/snco_pkg.sv
// Shared types, register codes and quarter-wave table arithmetic for the
// sine oscillator. No dependencies; imported by every module of the block except the checker.
package snco_pkg;

  localparam int unsigned INC_W = 32;
  localparam int unsigned MOD_W = 16;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [INC_W-1:0] FREQ_STEP_RST = 32'd42852281;
  localparam logic [GAIN_W-1:0] MOD_GAIN_RST = 16'd654;

  // pi/2 in unsigned Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULATED = 2'd0,
    CFG_FREQ_STEP = 2'd1,
    CFG_MOD_GAIN  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              modulated;
    logic [INC_W-1:0]  freq_step;
    logic [GAIN_W-1:0] mod_gain;
  } cfg_t;

  // Horner form of the Taylor series up to x^13, Q30, truncating throughout.
  // Only evaluated at elaboration to build the table.
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    t = ONE_Q30 - ((x2 * t) >> 30) / 156;
    t = ONE_Q30 - ((x2 * t) >> 30) / 110;
    t = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t = ONE_Q30 - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  // Entry k sits at the centre of its step: sin(pi/2 * (2k+1) / 2^(qbits+1)),
  // scaled to 2^(sbits-1)-1 with round half up and clamped.
  function automatic logic [63:0] quarter_entry(input logic [63:0] k,
                                                input logic [63:0] qbits,
                                                input logic [63:0] sbits);
    logic [63:0] x;
    logic [63:0] amp;
    logic [63:0] v;
    x = (HALF_PI_Q30 * (2 * k + 64'd1)) >> (qbits + 64'd1);
    amp = (64'd1 << (sbits - 64'd1)) - 64'd1;
    v = (sine_q30(x) * amp + (64'd1 << 29)) >> 30;
    if (v > amp) begin
      v = amp;
    end
    return v;
  endfunction

endpackage

### sv/snco_inc.sv
// Increment stage: forms the per-sample phase step from the modulation
// sample or the fixed step. Depends on snco_pkg.
module snco_inc import snco_pkg::*; (
  input  logic                    clk_i,
  input  logic                    load_i,
  input  cfg_t                    cfg_i,
  input  logic signed [MOD_W-1:0] mod_sample_i,
  output logic [INC_W-1:0]        inc_o
);

  logic [MOD_W-1:0] mod_offs;
  logic [INC_W-1:0] prod;
  logic [INC_W-1:0] inc_d;
  logic [INC_W-1:0] inc_q;

  // mod + 32768 is the sample with its sign bit flipped
  assign mod_offs = {~mod_sample_i[MOD_W-1], mod_sample_i[MOD_W-2:0]};
  assign prod = INC_W'(mod_offs) * INC_W'(cfg_i.mod_gain);
  assign inc_d = cfg_i.modulated ? prod : cfg_i.freq_step;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      inc_q <= inc_d;
    end
  end

  assign inc_o = inc_q;

endmodule

### sv/snco_phase.sv
// Phase accumulator and quadrant mapping onto a quarter-table address.
// Depends on snco_pkg.
module snco_phase import snco_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int QUARTER_TABLE_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [INC_W-1:0]              inc_i,
  output logic                          neg_o,
  output logic [QUARTER_TABLE_BITS-1:0] addr_o
);

  logic [PHASE_BITS-1:0]         phase_q;
  logic [PHASE_BITS-1:0]         phase_d;
  logic [PHASE_BITS-1:0]         inc_scaled;
  logic [1:0]                    quad;
  logic [QUARTER_TABLE_BITS-1:0] k;

  // step is given in 2^-32 turns; align it to the accumulator
  if (PHASE_BITS > INC_W) begin : g_up
    assign inc_scaled = {inc_i, {(PHASE_BITS - INC_W){1'b0}}};
  end else if (PHASE_BITS == INC_W) begin : g_eq
    assign inc_scaled = inc_i;
  end else begin : g_down
    assign inc_scaled = inc_i[INC_W-1 -: PHASE_BITS];
  end

  assign phase_d = phase_q + inc_scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
    end
  end

  assign quad = phase_q[PHASE_BITS-1 -: 2];
  assign k = phase_q[PHASE_BITS-3 -: QUARTER_TABLE_BITS];
  assign addr_o = quad[0] ? ~k : k;
  assign neg_o = quad[1];

endmodule

### sv/snco_rom.sv
// Quarter-wave sine ROM with registered read data.
// Contents built at elaboration from snco_pkg::quarter_entry.
module snco_rom import snco_pkg::*; #(
  parameter int QUARTER_TABLE_BITS = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [QUARTER_TABLE_BITS-1:0] addr_i,
  output logic [SAMPLE_BITS-2:0]        mag_o
);

  localparam int Depth = 2 ** QUARTER_TABLE_BITS;
  localparam int MagW = SAMPLE_BITS - 1;

  logic [MagW-1:0] rom_w [Depth];
  logic [MagW-1:0] mag_q;

  for (genvar k = 0; k < Depth; k++) begin : g_rom
    localparam logic [63:0] Entry = quarter_entry(64'(k), 64'(QUARTER_TABLE_BITS),
                                                  64'(SAMPLE_BITS));
    assign rom_w[k] = Entry[MagW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= rom_w[addr_i];
    end
  end

  assign mag_o = mag_q;

endmodule

### sv/sine_nco_with_fm.sv
// Sine oscillator with frequency modulation: each request on the slave stream
// is one sample tick; the result on the master stream is the sine of the
// phase before that tick, then the phase advances by the step. Fixed mode
// steps by freq_step (2^-32 turns); modulated mode steps by
// (mod_sample + 32768) * mod_gain. The sine is read from a quarter-wave ROM of
// 2^QUARTER_TABLE_BITS entries, no interpolation, amplitude 2^(SAMPLE_BITS-1)-1;
// entries sit at half-step offsets, so phase zero gives a small positive value.
// Throughput is one sample per clock while m_axis_tready holds; a request
// passes the increment, phase-update-plus-ROM-read and output registers.
// Stalls propagate stage by stage, so bubbles are squeezed out. The user must
// write configuration through the cfg port while the stream is idle; the
// block does not enforce it. Index 0 modulated, 1 freq_step, 2 mod_gain, 3 ignored.
// Depends on snco_pkg, snco_inc, snco_phase, snco_rom.
module sine_nco_with_fm import snco_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int QUARTER_TABLE_BITS = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [MOD_W-1:0]                    s_axis_tdata,   // [15:0] mod_sample
  // master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,   // sine_sample, zero pad
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]               cfg_data_i
);

  localparam int OutW = ((SAMPLE_BITS + 7) / 8) * 8;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulated <= 1'b0;
      cfg_q.freq_step <= FREQ_STEP_RST;
      cfg_q.mod_gain  <= MOD_GAIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_MODULATED: cfg_q.modulated <= cfg_data_i[0];
        CFG_FREQ_STEP: cfg_q.freq_step <= cfg_data_i[INC_W-1:0];
        CFG_MOD_GAIN:  cfg_q.mod_gain  <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // pipeline control: each stage takes a new request when empty or draining
  logic v1_q, v2_q, v3_q;
  logic r1, r2, r3;
  logic accept;
  logic adv12, adv23;

  assign r3 = !v3_q || m_axis_tready;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign s_axis_tready = r1;
  assign accept = s_axis_tvalid && r1;
  assign adv12 = v1_q && r2;
  assign adv23 = v2_q && r3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= s_axis_tvalid;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
    end
  end

  // stage 1: step for this tick
  logic [INC_W-1:0] inc;

  snco_inc u_inc (
    .clk_i        (clk_i),
    .load_i       (accept),
    .cfg_i        (cfg_q),
    .mod_sample_i (s_axis_tdata),
    .inc_o        (inc)
  );

  // stage 2: look up the current phase, then advance it, as the tick leaves stage 1
  logic                          neg;
  logic [QUARTER_TABLE_BITS-1:0] addr;
  logic [SAMPLE_BITS-2:0]        mag;
  logic                          neg_q;

  snco_phase #(
    .PHASE_BITS         (PHASE_BITS),
    .QUARTER_TABLE_BITS (QUARTER_TABLE_BITS)
  ) u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv12),
    .inc_i  (inc),
    .neg_o  (neg),
    .addr_o (addr)
  );

  snco_rom #(
    .QUARTER_TABLE_BITS (QUARTER_TABLE_BITS),
    .SAMPLE_BITS        (SAMPLE_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (adv12),
    .addr_i (addr),
    .mag_o  (mag)
  );

  always_ff @(posedge clk_i) begin
    if (adv12) begin
      neg_q <= neg;
    end
  end

  // stage 3: sign for the lower half cycle, output register
  logic [SAMPLE_BITS-1:0] sample_d;
  logic [SAMPLE_BITS-1:0] sample_q;

  assign sample_d = neg_q ? (SAMPLE_BITS'(0) - {1'b0, mag}) : {1'b0, mag};

  always_ff @(posedge clk_i) begin
    if (adv23) begin
      sample_q <= sample_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata = OutW'(sample_q);

endmodule

### sv/snco_chk.sv
// Port-level checker for the sine oscillator, bound to the top level.
// Depends only on the top-level ports.
module snco_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam logic [SAMPLE_BITS-1:0] MinCode = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // a request reaches the output when the sink keeps ready meanwhile
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing three cycles after request");

  // with no result pending the block must take requests
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

  // symmetric amplitude: the most negative code never appears
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[SAMPLE_BITS-1:0] != MinCode))
    else $error("sample outside amplitude");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind sine_nco_with_fm snco_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_snco_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
